FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the bloom filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define BFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define BFH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bfh_pkg.sv
// Shared types, constants and helper functions for the bloom filter unit.
package bfh_pkg;

  // Filter storage sizing
  localparam int MAX_FILTER_BITS = 65536;
  localparam int POS_W           = $clog2(MAX_FILTER_BITS);
  localparam int SIZE_W          = $clog2(MAX_FILTER_BITS + 1);
  localparam int ROW_BITS        = (MAX_FILTER_BITS < 64) ? MAX_FILTER_BITS : 64;
  localparam int ROW_IDX_W       = (ROW_BITS > 1) ? $clog2(ROW_BITS) : 1;
  localparam int ROWS            = (MAX_FILTER_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W           = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Register field widths
  localparam int CFG_BITS_W      = 17;
  localparam int COUNT_W         = 6;
  localparam int HASH_COUNT_MAX  = 32;

  // Register indexes
  localparam logic REG_FILTER_BITS = 1'b0;
  localparam logic REG_HASH_COUNT  = 1'b1;

  // Hashing
  localparam int          HASH_W      = 32;
  localparam logic [31:0] FNV_PRIME   = 32'h0100_0193;
  localparam logic [31:0] SEED_FIRST  = 32'h811C_9DC5;
  localparam logic [31:0] SEED_SECOND = 32'h0100_0193;

  // Remainder unit retires two dividend bits per cycle
  localparam int DIV_STEPS  = HASH_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Hand-off queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Finished key handed from the hashing front to the probe engine
  typedef struct packed {
    logic [HASH_W-1:0] first_hash;
    logic [HASH_W-1:0] second_hash;
    logic              operation;
  } key_hash_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_PROBE,
    ST_DONE
  } back_state_t;

  // One FNV-1a round, truncated to 32 bits
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-8){1'b0}}, b};
    return x * FNV_PRIME;
  endfunction

  // One restoring remainder step: shift in a bit, subtract the modulus if it fits
  function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] r,
                                                 input logic bit_in,
                                                 input logic [SIZE_W-1:0] modulus);
    logic [SIZE_W:0] t;
    t = {r, bit_in};
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[SIZE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bfh_front.sv
// Front end: takes key bytes and keeps the two running FNV-1a hashes.
module bfh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] key_byte
  input  logic                s_axis_tuser,  // [0] operation
  input  logic                s_axis_tlast,
  input  logic                clearing,
  input  logic                q_full,
  output logic                q_push,
  output bfh_pkg::key_hash_t  q_data
);
  import bfh_pkg::*;

  logic [HASH_W-1:0] first_hash;
  logic [HASH_W-1:0] second_hash;
  logic [HASH_W-1:0] first_next;
  logic [HASH_W-1:0] second_next;
  logic              accept;

  // Hold off input while the store is swept or the queue has no room
  assign s_axis_tready = !q_full && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign first_next  = fnv_step(first_hash, s_axis_tdata);
  assign second_next = fnv_step(second_hash, s_axis_tdata);

  // Push the finished hashes on the last byte of a key
  assign q_push              = accept && s_axis_tlast;
  assign q_data.first_hash   = first_next;
  assign q_data.second_hash  = second_next;
  assign q_data.operation    = s_axis_tuser;

  // Advance the hashes; return to the seeds after a key
  always_ff @(posedge clk) begin
    if (rst) begin
      first_hash  <= SEED_FIRST;
      second_hash <= SEED_SECOND;
    end else if (accept) begin
      if (s_axis_tlast) begin
        first_hash  <= SEED_FIRST;
        second_hash <= SEED_SECOND;
      end else begin
        first_hash  <= first_next;
        second_hash <= second_next;
      end
    end
  end

endmodule

FILE: rtl/core/bfh_queue.sv
// Two-entry queue of finished keys between the front end and the probe engine.
module bfh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bfh_pkg::key_hash_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output bfh_pkg::key_hash_t pop_data
);
  import bfh_pkg::*;

  key_hash_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign valid    = (fill != '0);
  assign pop_data = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/core/bfh_back.sv
// Probe engine: reduces the hashes, walks the probe positions and owns the bit store.
module bfh_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [bfh_pkg::CFG_BITS_W-1:0]     filter_bits,
  input  logic [bfh_pkg::COUNT_W-1:0]        hash_count,
  input  logic                               q_valid,
  input  bfh_pkg::key_hash_t                 q_data,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata   // [0] maybe_present
);
  import bfh_pkg::*;

  back_state_t          state;
  back_state_t          state_next;

  logic [ROW_BITS-1:0]  mem [ROWS];
  logic [ROW_W-1:0]     clr_row;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [HASH_W-1:0]    dvd_first;
  logic [HASH_W-1:0]    dvd_second;
  logic [SIZE_W-1:0]    rem_first;
  logic [SIZE_W-1:0]    rem_second;
  logic [SIZE_W-1:0]    rem_wrap;
  logic [SIZE_W-1:0]    wrap_rem;
  logic [SIZE_W-1:0]    size;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   probe_idx;
  logic [SIZE_W-1:0]    pos;
  logic [HASH_W-1:0]    sum;
  logic [HASH_W-1:0]    stride;
  logic                 is_check;
  logic                 present;
  logic                 rd_pending;
  logic [ROW_BITS-1:0]  rd_row;
  logic [ROW_IDX_W-1:0] rd_bit;
  logic                 out_bit;

  logic [SIZE_W-1:0]    size_next;
  logic [COUNT_W-1:0]   count_next;
  logic [SIZE_W-1:0]    rem_first_next;
  logic [SIZE_W-1:0]    rem_second_next;
  logic [SIZE_W-1:0]    rem_wrap_next;
  logic [SIZE_W-1:0]    wrap_rem_next;
  logic [SIZE_W:0]      wrap_inc;
  logic [SIZE_W:0]      adv_mod;
  logic [SIZE_W:0]      adv_wrap;
  logic [HASH_W:0]      sum_wide;
  logic [SIZE_W-1:0]    pos_next;
  logic [ROW_W-1:0]     pos_row;
  logic [ROW_IDX_W-1:0] pos_bit;
  logic                 present_eff;
  logic                 slot_free;
  logic                 emit;

  // Clamp the registers as the key starts
  always_comb begin
    if (filter_bits == '0) begin
      size_next = SIZE_W'(1);
    end else if (32'(filter_bits) > 32'(MAX_FILTER_BITS)) begin
      size_next = SIZE_W'(MAX_FILTER_BITS);
    end else begin
      size_next = SIZE_W'(filter_bits);
    end
    if (32'(hash_count) > 32'(HASH_COUNT_MAX)) begin
      count_next = COUNT_W'(HASH_COUNT_MAX);
    end else begin
      count_next = hash_count;
    end
  end

  // Two remainder steps per cycle on each lane; the wrap lane divides 2^32-1
  always_comb begin
    rem_first_next  = rem_step(rem_step(rem_first, dvd_first[HASH_W-1], size),
                               dvd_first[HASH_W-2], size);
    rem_second_next = rem_step(rem_step(rem_second, dvd_second[HASH_W-1], size),
                               dvd_second[HASH_W-2], size);
    rem_wrap_next   = rem_step(rem_step(rem_wrap, 1'b1, size), 1'b1, size);
    wrap_inc        = {1'b0, rem_wrap} + 1'b1;
    wrap_rem_next   = (wrap_inc == {1'b0, size}) ? '0 : wrap_inc[SIZE_W-1:0];
  end

  // Next probe position: add the stride remainder, fold back 2^32 on carry
  always_comb begin
    adv_mod = {1'b0, pos} + {1'b0, rem_second};
    if (adv_mod >= {1'b0, size}) begin
      adv_mod = adv_mod - {1'b0, size};
    end
    sum_wide = {1'b0, sum} + {1'b0, stride};
    adv_wrap = adv_mod;
    if (sum_wide[HASH_W]) begin
      if (adv_mod >= {1'b0, wrap_rem}) begin
        adv_wrap = adv_mod - {1'b0, wrap_rem};
      end else begin
        adv_wrap = adv_mod + {1'b0, size} - {1'b0, wrap_rem};
      end
    end
    pos_next = adv_wrap[SIZE_W-1:0];
    pos_row  = ROW_W'(pos >> ROW_IDX_W);
    pos_bit  = pos[ROW_IDX_W-1:0];
  end

  assign present_eff = present && !(rd_pending && !rd_row[rd_bit]);
  assign slot_free   = !m_axis_tvalid || m_axis_tready;
  assign emit        = (state == ST_DONE) && is_check && slot_free;
  assign clearing    = (state == ST_CLEAR);
  assign m_axis_tdata = {7'b0, out_bit};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue pop
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_W'(ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        state_next = (count == '0) ? ST_DONE : ST_PROBE;
      end
      ST_PROBE: begin
        if (probe_idx == COUNT_W'(count - 1'b1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!is_check || slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Bit store: sweep to zero after reset, set bits on add, read rows on check
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[clr_row] <= '0;
    end else if (state == ST_PROBE && !is_check) begin
      mem[pos_row][pos_bit] <= 1'b1;
    end
    if (state == ST_PROBE) begin
      rd_row <= mem[pos_row];
      rd_bit <= pos_bit;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row       <= '0;
      rd_pending    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      rd_pending <= (state == ST_PROBE) && is_check;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rd_pending && !rd_row[rd_bit]) begin
      present <= 1'b0;
    end
    if (emit) begin
      out_bit <= present_eff;
    end
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          dvd_first  <= q_data.first_hash;
          dvd_second <= q_data.second_hash;
          sum        <= q_data.first_hash;
          stride     <= q_data.second_hash;
          is_check   <= (q_data.operation == OP_CHECK);
          size       <= size_next;
          count      <= count_next;
          rem_first  <= '0;
          rem_second <= '0;
          rem_wrap   <= '0;
          div_cnt    <= '0;
        end
      end
      ST_DIV: begin
        rem_first  <= rem_first_next;
        rem_second <= rem_second_next;
        rem_wrap   <= rem_wrap_next;
        dvd_first  <= dvd_first << 2;
        dvd_second <= dvd_second << 2;
        div_cnt    <= div_cnt + 1'b1;
      end
      ST_FIX: begin
        wrap_rem  <= wrap_rem_next;
        pos       <= rem_first;
        probe_idx <= '0;
        present   <= 1'b1;
      end
      ST_PROBE: begin
        pos       <= pos_next;
        sum       <= sum_wide[HASH_W-1:0];
        probe_idx <= probe_idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/bloom_filter_fnv_double_hash_unit.sv
// Top level of the bloom filter unit: register port, hashing front, queue and probe engine.
//
// Keys arrive on the s_axis channel one byte per item: tdata carries the byte,
// tuser the operation (0 add, 1 check) and tlast marks the final byte. Each
// check key yields one item on m_axis with tdata[0] = maybe_present; adds and
// non-final bytes yield nothing. filter_bits (0x0) and hash_count (0x4) are
// written over the APB port; the user must do so only while the unit is idle,
// as the block itself does not enforce it. Bytes are taken one per cycle while
// the queue has room and the store is not being swept. A finished key waits in
// a two-entry queue for the probe engine, which loads it, reduces both hashes in
// the remainder unit (two bits of each hash per cycle), sets up the first probe,
// probes the single-port bit store hash_count times and then finishes the key
// before it takes the next one.
// After reset the bit store is swept to zero, one 64-bit row per cycle over
// 1024 rows; s_axis_tready stays low meanwhile, register writes still work.
// If the receiver stalls, the result stays in the output register, the engine
// holds on the next check key, and input backs up once the queue is full.
`include "assert_macros.svh"

module bloom_filter_fnv_double_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
  input  logic        s_axis_tuser,   // [0] operation
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] maybe_present, [7:1] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfh_pkg::*;

  logic [CFG_BITS_W-1:0] filter_bits;
  logic [COUNT_W-1:0]    hash_count;
  logic                  cfg_write;
  logic                  clearing;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  key_hash_t             q_push_data;
  key_hash_t             q_pop_data;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= CFG_BITS_W'(MAX_FILTER_BITS);
      hash_count  <= COUNT_W'(7);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_FILTER_BITS: filter_bits <= pwdata[CFG_BITS_W-1:0];
        REG_HASH_COUNT:  hash_count  <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILTER_BITS: prdata = {{(32-CFG_BITS_W){1'b0}}, filter_bits};
      REG_HASH_COUNT:  prdata = {{(32-COUNT_W){1'b0}}, hash_count};
      default:         prdata = '0;
    endcase
  end

  bfh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .clearing      (clearing),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_push_data)
  );

  bfh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  bfh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .filter_bits   (filter_bits),
    .hash_count    (hash_count),
    .q_valid       (q_valid),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Reset always starts the store sweep
  `BFH_ASSERT_NXT(a_reset_starts_sweep, rst, clearing, "sweep not started by reset")
  // No result may leave before the store is clean
  `BFH_ASSERT_IMP(a_no_result_in_sweep, clearing, !m_axis_tvalid, "result during sweep")
  // A finished key never finds the queue full
  `BFH_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "key queue overflow")
  // No key byte is taken during the sweep
  `BFH_ASSERT_IMP(a_no_input_in_sweep, s_axis_tvalid && s_axis_tready, !clearing,
                  "input taken during sweep")

endmodule

FILE: dv/bloom_filter_fnv_double_hash_unit_tb.sv
// Self-checking testbench for the bloom filter unit with FNV-1a double hashing.
`timescale 1ns / 100ps

module bloom_filter_fnv_double_hash_unit_tb;
  import bfh_pkg::*;

  // One directed step: optional register update, then one key byte
  typedef struct packed {
    logic        set_cfg;
    logic [16:0] cfg_bits;
    logic [5:0]  cfg_count;
    logic        op;
    logic [7:0]  key_byte;
    logic        last;
    logic        typed;
    logic        typed_present;
  } dir_row_t;

  // A whole key, kept so later checks can ask for keys that were added
  typedef struct packed {
    logic [15:0][7:0] bytes;
    logic [4:0]       len;
  } key_t;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;
  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [2:0] ADDR_FILTER_BITS = {REG_FILTER_BITS, 2'b00};
  localparam logic [2:0] ADDR_HASH_COUNT  = {REG_HASH_COUNT, 2'b00};

  // columns: set_cfg, filter_bits, hash_count, op, byte, last, typed, present
  localparam dir_row_t DIRECTED [23] = '{
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h00, 1'b1, 1'b1, 1'b0}, // empty store
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'hFF, 1'b1, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'hFF, 1'b1, 1'b1, 1'b1},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h12, 1'b0, 1'b0, 1'b0}, // op ignored mid-key
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'h34, 1'b0, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'hAB, 1'b1, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'h12, 1'b0, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h34, 1'b0, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'hAB, 1'b1, 1'b1, 1'b1},
    '{1'b1, 17'd65536,  6'd0,  OP_CHECK, 8'h5A, 1'b1, 1'b1, 1'b1}, // zero hash count
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'hC3, 1'b1, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'hC3, 1'b1, 1'b1, 1'b1},
    '{1'b1, 17'd0,      6'd63, OP_CHECK, 8'h77, 1'b1, 1'b0, 1'b0}, // size 0, count saturates
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'h01, 1'b1, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h99, 1'b1, 1'b1, 1'b1}, // every probe on bit 0
    '{1'b1, 17'h1FFFF,  6'd32, OP_ADD,   8'h80, 1'b1, 1'b0, 1'b0}, // size saturates
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h80, 1'b1, 1'b1, 1'b1},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h7F, 1'b1, 1'b0, 1'b0},
    '{1'b1, 17'd1,      6'd1,  OP_CHECK, 8'h3C, 1'b1, 1'b1, 1'b1},
    '{1'b1, 17'd65536,  6'd7,  OP_ADD,   8'h00, 1'b0, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_ADD,   8'hFF, 1'b1, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'h00, 1'b0, 1'b0, 1'b0},
    '{1'b0, 17'd0,      6'd0,  OP_CHECK, 8'hFF, 1'b1, 1'b1, 1'b1}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] key_byte
  logic        s_axis_tuser = 1'b0;    // [0] operation
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [0] maybe_present, [7:1] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state
  bit          filter_mem [0:MAX_FILTER_BITS-1];
  logic [31:0] run_h1 = SEED_FIRST;
  logic [31:0] run_h2 = SEED_SECOND;
  logic [16:0] cur_filter_bits = 17'd65536;
  logic [5:0]  cur_hash_count = 6'd7;

  bit          presence_due[$];
  key_t        added_keys[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned keys_sent = 0;
  int unsigned results_seen = 0;
  int unsigned present_seen = 0;
  int unsigned tx_burst = 0;
  bit          tx_steady = 0;
  bit          hold_req = 0;

  bloom_filter_fnv_double_hash_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // Hash one key byte; on the last byte probe the filter and reseed
  task automatic hash_key_byte(input logic op, input logic [7:0] kb, input logic last,
                               output bit has_result, output bit present);
    logic [31:0] size;
    logic [31:0] probes;
    logic [31:0] idx;
    logic [31:0] sum;
    logic [31:0] pos;
    run_h1 = (run_h1 ^ {24'd0, kb}) * FNV_PRIME;
    run_h2 = (run_h2 ^ {24'd0, kb}) * FNV_PRIME;
    has_result = 0;
    present = 1;
    if (last) begin
      size = (cur_filter_bits == 0) ? 32'd1 :
             (cur_filter_bits > MAX_FILTER_BITS) ? MAX_FILTER_BITS : {15'd0, cur_filter_bits};
      probes = (cur_hash_count > HASH_COUNT_MAX) ? HASH_COUNT_MAX : {26'd0, cur_hash_count};
      for (idx = 0; idx < probes; idx++) begin
        sum = run_h1 + idx * run_h2;
        pos = sum % size;
        if (op == OP_ADD) filter_mem[pos] = 1'b1;
        else if (!filter_mem[pos]) present = 0;
      end
      run_h1 = SEED_FIRST;
      run_h2 = SEED_SECOND;
      has_result = (op == OP_CHECK);
    end
  endtask

  // Offer one byte in bursts with random gaps; predict once it is taken
  task automatic send_byte(input logic op, input logic [7:0] kb, input logic last,
                           input bit typed, input bit typed_present);
    int unsigned gap;
    bit has_result;
    bit present;
    if (tx_burst == 0) begin
      tx_burst = $urandom_range(1, 24);
      gap = tx_steady ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 4);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= kb;
    s_axis_tuser  <= op;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tx_burst--;
    bytes_sent++;
    if (last) keys_sent++;
    hash_key_byte(op, kb, last, has_result, present);
    if (has_result) presence_due.push_back(typed ? typed_present : present);
  endtask

  task automatic send_key(input logic op, input key_t k);
    int unsigned j;
    for (j = 0; j < k.len; j++) begin
      if (j == k.len - 1) send_byte(op, k.bytes[j], 1'b1, 0, 0);
      else send_byte(1'($urandom_range(0, 1)), k.bytes[j], 1'b0, 0, 0);
    end
  endtask

  // Drop valid, wait for all results, then let in-flight adds finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    tx_burst = 0;
    @(posedge clk);
    while (presence_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [16:0] fbits, input logic [5:0] count);
    apb_write(ADDR_FILTER_BITS, {15'd0, fbits});
    cur_filter_bits = fbits;
    apb_write(ADDR_HASH_COUNT, {26'd0, count});
    cur_hash_count = count;
  endtask

  // Receiver: rotate stall patterns, or hold off on request
  logic [11:0] rx_cycle = 12'd0;
  bit          hold_seen = 0;
  int unsigned hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 12'd1;
      if (hold_req != hold_seen) begin
        hold_seen     <= hold_req;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: m_axis_tready <= 1'b1;
          2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
          2'd2: m_axis_tready <= (rx_cycle[1:0] == 2'd0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each result with the oldest pending presence
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[0]) present_seen++;
      if (presence_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d", $time, m_axis_tdata);
      end else if (m_axis_tdata !== {7'd0, presence_due[0]}) begin
        errors++;
        $display("%0t: maybe_present mismatch, expected %0d, actual %0d",
                 $time, {7'd0, presence_due[0]}, m_axis_tdata);
        void'(presence_due.pop_front());
      end else begin
        void'(presence_due.pop_front());
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned p;
    int unsigned phase_items;
    int unsigned j;
    int unsigned roll;
    bit paused;
    logic [16:0] fbits;
    logic [5:0] count;
    logic op;
    key_t k;

    for (j = 0; j < MAX_FILTER_BITS; j++) filter_mem[j] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (r = 0; r < 23; r++) begin
      if (DIRECTED[r].set_cfg) begin
        settle();
        write_cfg(DIRECTED[r].cfg_bits, DIRECTED[r].cfg_count);
      end
      send_byte(DIRECTED[r].op, DIRECTED[r].key_byte, DIRECTED[r].last,
                DIRECTED[r].typed, DIRECTED[r].typed_present);
    end

    // Random keys over several filter settings
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fbits = 17'd65536; count = 6'd7; end
        1: begin fbits = 17'($urandom_range(1, 64)); count = 6'($urandom_range(1, 8)); end
        2: begin fbits = 17'h1FFFF; count = 6'd63; end
        3: begin
          fbits = 17'($urandom_range(1024, 65536));
          count = 6'($urandom_range(0, 32));
        end
        4: begin fbits = 17'd0; count = 6'($urandom_range(1, 63)); end
        5: begin
          fbits = 17'($urandom_range(0, 131071));
          count = 6'($urandom_range(0, 63));
        end
        6: begin
          fbits = 17'($urandom_range(100, 4000));
          count = 6'($urandom_range(2, 12));
        end
        default: begin fbits = 17'd65536; count = 6'd32; end
      endcase
      settle();
      write_cfg(fbits, count);
      tx_steady = (p == 2);
      paused = 0;
      phase_items = 0;
      // receiver holds off while the sender keeps offering keys
      if (p == 3) hold_req <= ~hold_req;
      while (phase_items < PHASE_ITEMS) begin
        if (p == 5 && !paused && phase_items >= PHASE_ITEMS / 2) begin
          paused = 1;
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
          while (presence_due.size() != 0) @(posedge clk);
        end
        roll = $urandom_range(0, 99);
        op = (roll < 45) ? OP_ADD : OP_CHECK;
        if (op == OP_CHECK && added_keys.size() != 0 && $urandom_range(0, 9) < 6) begin
          k = added_keys[$urandom_range(0, added_keys.size() - 1)];
        end else begin
          roll = $urandom_range(0, 99);
          k.len = (roll < 80) ? 5'($urandom_range(1, 4)) :
                  (roll < 95) ? 5'($urandom_range(5, 10)) : 5'($urandom_range(11, 16));
          for (j = 0; j < 16; j++) k.bytes[j] = 8'($urandom_range(0, 255));
        end
        send_key(op, k);
        phase_items += k.len;
        if (op == OP_ADD) begin
          added_keys.push_back(k);
          if (added_keys.size() > 64) void'(added_keys.pop_front());
        end
      end
    end

    settle();
    $display("covered %0d key bytes in %0d keys over %0d random filter settings",
             bytes_sent, keys_sent, PHASES);
    $display("checked %0d membership results, %0d of them maybe-present",
             results_seen, present_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bfh_pkg.sv
rtl/core/bfh_front.sv
rtl/core/bfh_queue.sv
rtl/core/bfh_back.sv
rtl/core/bloom_filter_fnv_double_hash_unit.sv
dv/bloom_filter_fnv_double_hash_unit_tb.sv
